FILE: hdl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

   localparam int TYPE_W = 3;
   localparam int POS_W  = 10;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 11;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR  = 3'd0,
      REQ_APPEND = 3'd1,
      REQ_INSERT = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_CHANGE = 3'd4,
      REQ_READ   = 3'd5
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_RD_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TYPE_W-1:0]       req_type;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        length;
   } rsp_item_type;

endpackage

FILE: hdl/ple_req_if.sv
`timescale 1ns / 1ps

interface ple_req_if;
   import ple_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink   (input valid, req_type, position, value, output ready);
endinterface

FILE: hdl/ple_rsp_if.sv
`timescale 1ns / 1ps

interface ple_rsp_if;
   import ple_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [VAL_W-1:0] read_value;
   logic [LEN_W-1:0]        length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink   (input valid, status, read_value, length, output ready);
endinterface

FILE: hdl/ple_mem.sv
`timescale 1ns / 1ps

module ple_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic signed [ple_pkg::VAL_W-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic signed [ple_pkg::VAL_W-1:0] rd_data
);
   import ple_pkg::*;

   logic signed [VAL_W-1:0] store [DEPTH];
   logic signed [VAL_W-1:0] rd_data_ff;

   // Entries are undefined until written, so the array has no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl #(
   parameter int CAPACITY = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_accept,
   input  ple_pkg::req_item_type            req_item,
   output logic                             idle,
   input  logic                             out_free,
   output logic                             res_load,
   output ple_pkg::rsp_item_type            res_item,
   output logic                             mem_we,
   output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
   output logic signed [ple_pkg::VAL_W-1:0] mem_wdata,
   output logic                             mem_re,
   output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
   input  logic signed [ple_pkg::VAL_W-1:0] mem_rdata
);
   import ple_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   state_type               state_ff, state_in;
   req_code_type            kind_ff, kind_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              status_ff, status_in;
   logic signed [VAL_W-1:0] rdval_ff, rdval_in;

   logic [WIDE_W-1:0] pos_wide;
   logic [WIDE_W-1:0] cnt_wide;
   logic [ADDR_W-1:0] pos_addr;
   logic [ADDR_W-1:0] cnt_addr;
   logic              in_range;
   logic              full;
   logic              step_up;
   logic [ADDR_W-1:0] step_out;
   logic [CNT_W-1:0]  cnt_step;
   logic              del_last;

   assign pos_wide = WIDE_W'(pos_ff);
   assign cnt_wide = WIDE_W'(count_ff);
   assign pos_addr = pos_wide[ADDR_W-1:0];
   assign cnt_addr = count_ff[ADDR_W-1:0];
   assign in_range = pos_wide < cnt_wide;
   assign full     = count_ff == CNT_W'(CAPACITY);

   // The one index stepper walks up through the list for a delete and down for an insert.
   assign step_up  = kind_ff == REQ_DELETE;
   assign step_out = idx_ff + (step_up ? ADDR_W'(1) : {ADDR_W{1'b1}});

   // Length counter: only a delete decrements it.
   assign cnt_step = count_ff + (step_up ? {CNT_W{1'b1}} : CNT_W'(1));
   assign del_last = pos_wide == WIDE_W'(cnt_step);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (kind_ff)
               REQ_INSERT: state_in = (in_range && !full) ? ST_INS_RD : ST_FINISH;
               REQ_DELETE: state_in = (in_range && !del_last) ? ST_DEL_RD : ST_FINISH;
               REQ_READ:   state_in = in_range ? ST_RD_WAIT : ST_FINISH;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR:  state_in = (step_out == pos_addr) ? ST_INS_PUT : ST_INS_RD;
         ST_INS_PUT: state_in = ST_FINISH;
         ST_DEL_RD:  state_in = ST_DEL_WR;
         ST_DEL_WR:  state_in = (WIDE_W'(step_out) == cnt_wide) ? ST_FINISH : ST_DEL_RD;
         ST_RD_WAIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idle      = 1'b0;
      res_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = step_out;
      unique case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_DECIDE: begin
            case (kind_ff)
               REQ_APPEND: begin
                  mem_we    = !full;
                  mem_waddr = cnt_addr;
                  mem_wdata = val_ff;
               end
               REQ_CHANGE: begin
                  mem_we    = in_range;
                  mem_waddr = pos_addr;
                  mem_wdata = val_ff;
               end
               REQ_READ: begin
                  mem_re    = in_range;
                  mem_raddr = pos_addr;
               end
               default: ;
            endcase
         end
         ST_INS_RD, ST_DEL_RD: mem_re = 1'b1;
         ST_INS_WR, ST_DEL_WR: mem_we = 1'b1;
         ST_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
            mem_wdata = val_ff;
         end
         ST_RD_WAIT: ;
         ST_FINISH: res_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_code_type'(req_item.req_type);
               pos_in  = req_item.position;
               val_in  = req_item.value;
            end
         end
         ST_DECIDE: begin
            status_in = STAT_DONE;
            rdval_in  = '1;
            case (kind_ff)
               REQ_CLEAR: count_in = '0;
               REQ_APPEND: begin
                  if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     count_in = cnt_step;
                  end
               end
               REQ_INSERT: begin
                  if (!in_range) begin
                     status_in = STAT_RANGE;
                  end else if (full) begin
                     status_in = STAT_FULL;
                  end else begin
                     idx_in = cnt_addr;
                  end
               end
               REQ_DELETE: begin
                  if (!in_range) begin
                     status_in = STAT_RANGE;
                  end else begin
                     count_in = cnt_step;
                     idx_in   = pos_addr;
                  end
               end
               REQ_CHANGE, REQ_READ: begin
                  if (!in_range) begin
                     status_in = STAT_RANGE;
                  end
               end
               default: ;
            endcase
         end
         ST_INS_WR, ST_DEL_WR: idx_in = step_out;
         ST_INS_PUT: count_in = cnt_step;
         ST_RD_WAIT: rdval_in = mem_rdata;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   assign res_item.status     = status_ff;
   assign res_item.read_value = rdval_ff;
   assign res_item.length     = cnt_wide[LEN_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length exceeds capacity");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE)
      else $error("request taken while busy");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory read and write in the same cycle");

   a_ins_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_WR |-> $past(state_ff) == ST_INS_RD)
      else $error("insert write without preceding read");

   a_put_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_PUT |-> count_ff < CNT_W'(CAPACITY))
      else $error("insert completed on a full list");

endmodule

FILE: hdl/positional_list_engine_top.sv
`timescale 1ns / 1ps
// Clear, append, change, read, rejected and unused requests move no entries. An insert moves
// length minus position entries, each by a read and a write; a delete moves length minus
// position minus one. The result is registered in the sequencer, then in the output register
// that drives the response channel, where it waits until the consumer takes it.
// Reset, synchronous and active high, empties the list; stored entries are not cleared.

module positional_list_engine_top #(
   parameter int CAPACITY = 1024
) (
   input logic        clock,
   input logic        reset,
   ple_req_if.sink    req_chan,
   ple_rsp_if.source  rsp_chan
);
   import ple_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);

   // Request side: a transfer is taken only while the sequencer is idle.
   req_item_type            req_item;
   logic                    req_accept;
   logic                    ctrl_idle;

   // Result side: a single output register decouples the sequencer from the consumer,
   // so the next request may be taken while a result still waits for its transfer.
   logic                    out_free;
   logic                    res_load;
   rsp_item_type            res_item;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   // Memory port between the sequencer and the entry store.
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic signed [VAL_W-1:0] mem_wdata;
   logic                    mem_re;
   logic [ADDR_W-1:0]       mem_raddr;
   logic signed [VAL_W-1:0] mem_rdata;

   assign req_item.req_type = req_chan.req_type;
   assign req_item.position = req_chan.position;
   assign req_item.value    = req_chan.value;
   assign req_chan.ready    = ctrl_idle;
   assign req_accept        = req_chan.valid & ctrl_idle;

   // The sequencer may load a new result when the register is empty or is being drained.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_item_ff.status;
   assign rsp_chan.read_value = rsp_item_ff.read_value;
   assign rsp_chan.length     = rsp_item_ff.length;

   // The sequencer moves entries one at a time: a read of the source position, then a
   // write of the destination, with a single index stepper shared by insert and delete.
   ple_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_item),
      .idle       (ctrl_idle),
      .out_free   (out_free),
      .res_load   (res_load),
      .res_item   (res_item),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // The entry store has one write and one registered read per cycle.
   ple_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

FILE: sim/positional_list_engine_top_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
   import ple_pkg::*;

   // The list is built at its full size so that the full-list status can be reached
   // by filling it once.
   localparam int LIST_CAP    = 1024;
   localparam int RANDOM_REQS = 650;
   // The slowest transfer-free stretch is a delete at the head of a full list, which moves
   // every other entry, so this bound leaves a wide margin.
   localparam int STALL_LIMIT = 20000;
   localparam int IDLE_PCT    = 37;
   localparam int SETTLE_CYC  = 64;

   // Request codes that the block must treat as no operation.
   localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

   // Mirror of the list contents. It predicts the response to every accepted request and
   // holds those predictions until the block returns them in order.
   class list_mirror;
      logic signed [VAL_W-1:0] slots [LIST_CAP];
      int                      fill;
      rsp_item_type            awaited [$];
      int                      fail_count;

      function void note_request(req_item_type item);
         rsp_item_type due;
         int           p;
         bit           in_range;
         p               = int'(item.position);
         in_range        = p < fill;
         due.status      = STAT_DONE;
         due.read_value  = '1;
         case (item.req_type)
            REQ_CLEAR: begin
               fill = 0;
            end
            REQ_APPEND: begin
               if (fill >= LIST_CAP) begin
                  due.status = STAT_FULL;
               end else begin
                  slots[fill] = item.value;
                  fill++;
               end
            end
            REQ_INSERT: begin
               // The position is checked before the capacity.
               if (!in_range) begin
                  due.status = STAT_RANGE;
               end else if (fill >= LIST_CAP) begin
                  due.status = STAT_FULL;
               end else begin
                  for (int i = fill; i > p; i--) slots[i] = slots[i-1];
                  slots[p] = item.value;
                  fill++;
               end
            end
            REQ_DELETE: begin
               if (!in_range) begin
                  due.status = STAT_RANGE;
               end else begin
                  for (int i = p; i < fill - 1; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            REQ_CHANGE: begin
               if (!in_range) due.status = STAT_RANGE;
               else slots[p] = item.value;
            end
            REQ_READ: begin
               if (!in_range) due.status = STAT_RANGE;
               else due.read_value = slots[p];
            end
            default: begin
            end
         endcase
         due.length = LEN_W'(fill);
         awaited.push_back(due);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type due;
         if (awaited.size() == 0) begin
            $display("%0t: response with none awaited: status %0d read_value %0d length %0d",
                     $time, got.status, got.read_value, got.length);
            fail_count++;
            return;
         end
         due = awaited.pop_front();
         if (got.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, got.status);
            fail_count++;
         end
         if (got.read_value !== due.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, due.read_value, got.read_value);
            fail_count++;
         end
         if (got.length !== due.length) begin
            $display("%0t: length expected %0d actual %0d", $time, due.length, got.length);
            fail_count++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   bit           calm;
   int           stall_cycles;
   rsp_item_type seen;
   list_mirror   mirror;

   ple_req_if req_chan ();
   ple_rsp_if rsp_chan ();

   positional_list_engine_top #(
      .CAPACITY (LIST_CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The response side holds ready low at random, except during the calm stretch where it
   // accepts every response at once.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Responses are sampled at the rising edge and compared in order. The same process counts
   // cycles in which neither channel makes a transfer, and gives up if that count grows too
   // large.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status     = rsp_chan.status;
         seen.read_value = rsp_chan.read_value;
         seen.length     = rsp_chan.length;
         mirror.check_response(seen);
      end
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("positional_list_engine_top: mismatch");
         $finish;
      end
   end

   // Offers one request, idling first at random, and returns at the falling edge after its
   // transfer with valid still high. The mirror is updated at the edge of the transfer.
   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      req_item_type item;
      item.req_type = kind;
      item.position = pos;
      item.value    = val;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.position <= pos;
      req_chan.value    <= val;
      do @(posedge clock); while (!req_chan.ready);
      mirror.note_request(item);
      @(negedge clock);
   endtask

   // Withholds requests until every predicted response has come back. The wait runs through a
   // falling edge even when nothing is awaited, so that valid is never lowered and raised within the same step.
   task automatic await_all_responses();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (mirror.awaited.size() != 0);
   endtask

   // Positions mostly fall inside the list, with some exactly at its end and some anywhere
   // in the field's range.
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(9);
      if (mirror.fill == 0 || r == 0) return POS_W'($urandom_range((1 << POS_W) - 1));
      if (r == 1) return POS_W'(mirror.fill);
      return POS_W'($urandom_range(mirror.fill - 1));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_request();
      int                roll;
      logic [TYPE_W-1:0] kind;
      roll = $urandom_range(99);
      if (roll < 3)       kind = REQ_CLEAR;
      else if (roll < 5)  kind = roll[0] ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      else if (roll < 25) kind = REQ_APPEND;
      else if (roll < 45) kind = REQ_INSERT;
      else if (roll < 60) kind = REQ_DELETE;
      else if (roll < 75) kind = REQ_CHANGE;
      else                kind = REQ_READ;
      // Inserts and deletes move entries one at a time, so the list is kept short.
      if (mirror.fill > 40 && (kind == REQ_APPEND || kind == REQ_INSERT) && $urandom_range(1))
         kind = REQ_DELETE;
      send_request(kind, pick_position(), pick_value());
   endtask

   initial begin
      mirror             = new;
      reset              = 1'b1;
      calm               = 1'b0;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_CLEAR;
      req_chan.position  = '0;
      req_chan.value     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests. On an empty list every positional request is out of range, an
      // insert exactly at the end included.
      send_request(REQ_READ,   10'd0,    32'h1234_5678);
      send_request(REQ_DELETE, 10'd0,    32'h0000_0000);
      send_request(REQ_INSERT, 10'd0,    32'h0000_0001);
      send_request(REQ_CHANGE, 10'd1023, 32'hffff_ffff);
      // Build a short list with the extreme values and check its order.
      send_request(REQ_APPEND, 10'd1023, 32'h7fff_ffff);
      send_request(REQ_APPEND, 10'd0,    32'h8000_0000);
      send_request(REQ_INSERT, 10'd0,    32'hffff_ffff);
      send_request(REQ_INSERT, 10'd2,    32'h0000_0000);
      send_request(REQ_INSERT, 10'd4,    32'h0bad_f00d);
      send_request(REQ_READ,   10'd0,    32'h0000_0000);
      send_request(REQ_READ,   10'd1,    32'h0000_0000);
      send_request(REQ_READ,   10'd2,    32'h0000_0000);
      send_request(REQ_READ,   10'd3,    32'h0000_0000);
      send_request(REQ_CHANGE, 10'd1,    32'h5a5a_a5a5);
      send_request(REQ_READ,   10'd1,    32'hffff_ffff);
      send_request(REQ_DELETE, 10'd3,    32'h0000_0000);
      send_request(REQ_DELETE, 10'd0,    32'h0000_0000);
      send_request(REQ_READ,   10'd0,    32'h0000_0000);
      // Unused codes change nothing, whatever their fields hold.
      send_request(REQ_UNUSED_LO, 10'd1023, 32'hffff_ffff);
      send_request(REQ_UNUSED_HI, 10'd0,    32'h8000_0000);
      send_request(REQ_READ,   10'd1023, 32'h0000_0000);
      send_request(REQ_CLEAR,  10'd1023, 32'hffff_ffff);
      send_request(REQ_READ,   10'd0,    32'h0000_0000);
      send_request(REQ_APPEND, 10'd0,    32'h0000_0000);

      for (int n = 0; n < RANDOM_REQS; n++) begin
         calm = (n >= 200 && n < 450);
         if (n == 100) await_all_responses();
         if (n == 500) begin
            // Fill the list to capacity from a drained block, then probe both of its ends.
            await_all_responses();
            send_request(REQ_CLEAR, pick_position(), pick_value());
            while (mirror.fill < LIST_CAP) send_request(REQ_APPEND, pick_position(), $urandom);
            send_request(REQ_APPEND, 10'd0,    32'h7fff_ffff);
            send_request(REQ_INSERT, POS_W'($urandom_range(LIST_CAP - 1)), pick_value());
            send_request(REQ_INSERT, 10'd1023, 32'h8000_0000);
            send_request(REQ_READ,   10'd0,    32'h0000_0000);
            send_request(REQ_READ,   10'd1023, 32'h0000_0000);
            send_request(REQ_READ,   POS_W'($urandom_range(LIST_CAP - 1)), 32'h0000_0000);
            send_request(REQ_CHANGE, 10'd1023, 32'h8000_0000);
            send_request(REQ_READ,   10'd1023, 32'h0000_0000);
            send_request(REQ_DELETE, 10'd1023, 32'h0000_0000);
            send_request(REQ_READ,   10'd1023, 32'h0000_0000);
            send_request(REQ_INSERT, 10'd1022, 32'h7fff_ffff);
            send_request(REQ_INSERT, 10'd5,    32'h0000_0001);
            // A delete at the head moves every remaining entry.
            send_request(REQ_DELETE, 10'd0,    32'h0000_0000);
            send_request(REQ_READ,   10'd0,    32'h0000_0000);
            send_request(REQ_APPEND, 10'd0,    32'hffff_ffff);
            send_request(REQ_APPEND, 10'd0,    32'h0000_0000);
            send_request(REQ_READ,   10'd1023, 32'h0000_0000);
            send_request(REQ_CLEAR,  10'd0,    32'h0000_0000);
         end
         send_random_request();
      end
      calm = 1'b0;

      // Let every awaited response arrive, then allow some time for any stray one.
      req_chan.valid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mirror.fail_count == 0) begin
         $display("positional_list_engine_top: match");
      end else begin
         $display("positional_list_engine_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/ple_pkg.sv
hdl/ple_req_if.sv
hdl/ple_rsp_if.sv
hdl/ple_mem.sv
hdl/ple_ctrl.sv
hdl/positional_list_engine_top.sv
sim/positional_list_engine_top_tb.sv
